// ===== rtl/jns_pkg.sv =====
package jns_pkg;

    // Transaction kinds carried on s_tuser.
    localparam logic [1:0] CMD_WRITE_BUF  = 2'd0;
    localparam logic [1:0] CMD_WRITE_CTRL = 2'd1;
    localparam logic [1:0] CMD_READ_TDO   = 2'd2;
    localparam logic [1:0] CMD_TICK       = 2'd3;

    localparam int CMD_W     = 2;
    localparam int ADDR_W    = 10;
    localparam int COUNT_W   = 24;
    localparam int SHIFT_W   = 31;
    localparam int RDATA_W   = 32;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // Work handed from the control stage to the execute stage.
    typedef struct packed {
        logic is_read;
        logic exec_tick;
        logic high_nibble;
        logic mode_test;
        logic tdo;
        logic done_toggle;
        logic busy;
    } stage_t;

    // Control-stage status, watched by the checks at the top level.
    typedef struct packed {
        logic running;
        logic left_zero;
    } ctrl_status_t;

endpackage

// ===== rtl/jns_cmd_buf.sv =====
module jns_cmd_buf #(
    parameter int BUFFER_BYTES = 1024,
    parameter int AW           = 10
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [jns_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [7:0]                 rd_data
);

    logic [7:0]    mem [BUFFER_BYTES];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] wr_index;

    // The byte address is taken modulo the buffer size.
    generate
        if (BUFFER_BYTES >= (1 << jns_pkg::ADDR_W)) begin : g_direct
            assign wr_index = AW'(wr_addr);
        end else begin : g_reduce
            always_comb begin
                logic [jns_pkg::ADDR_W-1:0] r;
                r = wr_addr;
                for (int k = 5; k >= 0; k--) begin
                    if ({22'd0, r} >= (32'(BUFFER_BYTES) << k)) begin
                        r = r - jns_pkg::ADDR_W'(32'(BUFFER_BYTES) << k);
                    end
                end
                wr_index = AW'(r);
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_index] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/jns_ctrl.sv =====
module jns_ctrl #(
    parameter int BUFFER_BYTES = 1024,
    parameter int AW           = 10,
    parameter int IW           = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [jns_pkg::CMD_W-1:0]   cmd,
    input  logic                        start_bit,
    input  logic                        use_test_rst,
    input  logic [jns_pkg::COUNT_W-1:0] command_count,
    input  logic                        tdo_pin,
    input  logic                        s1_ready,
    output logic                        s1_valid,
    output jns_pkg::stage_t             s1_stage,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    output jns_pkg::ctrl_status_t       status
);

    logic [IW-1:0]               index_reg, index_next;
    logic [jns_pkg::COUNT_W-1:0] left_reg, left_next, left_dec;
    logic                        running_reg, running_next;
    logic                        done_reg, done_next;
    logic                        last_start_reg, last_start_next;
    logic                        mode_reg, mode_next;
    logic                        s1_valid_reg, s1_valid_next;
    jns_pkg::stage_t             s1_stage_reg, s1_stage_next;
    logic                        is_tick;

    assign is_tick  = accept && (cmd == jns_pkg::CMD_TICK) && running_reg;
    assign left_dec = left_reg - jns_pkg::COUNT_W'(1);

    always_comb begin
        index_next      = index_reg;
        left_next       = left_reg;
        running_next    = running_reg;
        done_next       = done_reg;
        last_start_next = last_start_reg;
        mode_next       = mode_reg;
        if (accept && (cmd == jns_pkg::CMD_WRITE_CTRL)) begin
            if (start_bit && !last_start_reg && !running_reg) begin
                mode_next  = use_test_rst;
                index_next = '0;
                left_next  = command_count;
                if (command_count == '0) begin
                    done_next = ~done_reg;
                end else begin
                    running_next = 1'b1;
                end
            end
            last_start_next = start_bit;
        end
        if (is_tick) begin
            if (index_reg == IW'(2 * BUFFER_BYTES - 1)) begin
                index_next = '0;
            end else begin
                index_next = index_reg + IW'(1);
            end
            left_next = left_dec;
            if (left_dec == '0) begin
                running_next = 1'b0;
                done_next    = ~done_reg;
            end
        end
    end

    always_comb begin
        s1_stage_next.is_read     = (cmd == jns_pkg::CMD_READ_TDO);
        s1_stage_next.exec_tick   = is_tick;
        s1_stage_next.high_nibble = index_reg[0];
        s1_stage_next.mode_test   = mode_reg;
        s1_stage_next.tdo         = tdo_pin;
        s1_stage_next.done_toggle = done_next;
        s1_stage_next.busy        = running_next;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_ready) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg      <= '0;
            left_reg       <= '0;
            running_reg    <= 1'b0;
            done_reg       <= 1'b0;
            last_start_reg <= 1'b0;
            mode_reg       <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end else begin
            index_reg      <= index_next;
            left_reg       <= left_next;
            running_reg    <= running_next;
            done_reg       <= done_next;
            last_start_reg <= last_start_next;
            mode_reg       <= mode_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_stage_reg <= s1_stage_next;
        end
    end

    assign rd_en            = is_tick;
    assign rd_addr          = index_reg[IW-1:1];
    assign s1_valid         = s1_valid_reg;
    assign s1_stage         = s1_stage_reg;
    assign status.running   = running_reg;
    assign status.left_zero = (left_reg == '0);

endmodule

// ===== rtl/jns_exec.sv =====
module jns_exec (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s1_valid,
    input  jns_pkg::stage_t             s1_stage,
    input  logic [7:0]                  rd_data,
    output logic                        s1_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [jns_pkg::RDATA_W-1:0] read_data,
    output logic                        tck_pulse,
    output logic                        tms_out,
    output logic                        tdi_out,
    output logic                        test_out,
    output logic                        rst_out,
    output logic                        busy_res
);

    logic                        advance, take;
    logic [3:0]                  nib;
    logic                        m_valid_reg, m_valid_next;
    logic [jns_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic                        tms_reg, tms_next;
    logic                        tdi_reg, tdi_next;
    logic                        test_reg, test_next;
    logic                        rst_reg, rst_next;
    logic [jns_pkg::RDATA_W-1:0] read_data_reg, read_data_next;
    logic                        tck_reg, tck_next;
    logic                        busy_reg;

    assign advance = !m_valid_reg || m_ready;
    assign take    = advance && s1_valid;
    assign nib     = s1_stage.high_nibble ? rd_data[7:4] : rd_data[3:0];

    always_comb begin
        shift_next     = shift_reg;
        tms_next       = tms_reg;
        tdi_next       = tdi_reg;
        test_next      = test_reg;
        rst_next       = rst_reg;
        tck_next       = 1'b0;
        read_data_next = '0;
        if (s1_stage.is_read) begin
            read_data_next = {s1_stage.done_toggle, shift_reg};
        end
        if (s1_stage.exec_tick) begin
            if (!s1_stage.mode_test) begin
                tck_next = nib[0];
                tms_next = nib[1];
                tdi_next = nib[2];
                if (nib[3]) begin
                    shift_next = {shift_reg[jns_pkg::SHIFT_W-2:0], s1_stage.tdo};
                end
            end else begin
                rst_next  = nib[1];
                test_next = nib[2];
            end
        end
        if (advance) begin
            m_valid_next = s1_valid;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            shift_reg   <= '0;
            tms_reg     <= 1'b0;
            tdi_reg     <= 1'b0;
            test_reg    <= 1'b0;
            rst_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (take) begin
                shift_reg <= shift_next;
                tms_reg   <= tms_next;
                tdi_reg   <= tdi_next;
                test_reg  <= test_next;
                rst_reg   <= rst_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            read_data_reg <= read_data_next;
            tck_reg       <= tck_next;
            busy_reg      <= s1_stage.busy;
        end
    end

    assign s1_ready  = advance;
    assign m_valid   = m_valid_reg;
    assign read_data = read_data_reg;
    assign tck_pulse = tck_reg;
    assign tms_out   = tms_reg;
    assign tdi_out   = tdi_reg;
    assign test_out  = test_reg;
    assign rst_out   = rst_reg;
    assign busy_res  = busy_reg;

endmodule

// ===== rtl/jtag_nibble_command_sequencer.sv =====
// JTAG nibble command sequencer. Bytes written to the command buffer hold two
// 4-bit commands each, low nibble first; a control write whose start bit rises
// from 0 to 1 begins a run of the given number of commands, one per tick
// transaction, with the command index wrapping round the buffer. Every input
// transaction (buffer write, control write, TDO register read or tick) yields
// exactly one result transaction carrying the read data, the TCK pulse flag,
// the four pin levels and the busy flag. The block takes one transaction per
// cycle unless the output register is stalled. The control stage updates the
// run counters and reads the command byte from the synchronous buffer RAM,
// whose single read port sets the rate of one command per cycle; the execute
// stage decodes the nibble into the pins and the TDO shift register and loads
// the output register. Buffer entries must be written before a run reads them.
module jtag_nibble_command_sequencer #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] buf_addr, [17:10] buf_data, [18] start_bit, [19] use_test_rst,
    // [43:20] command_count, [44] tdo_pin, [47:45] zero
    input  logic [47:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] read_data, [32] tck_pulse, [33] tms_out, [34] tdi_out,
    // [35] test_out, [36] rst_out, [37] busy_res, [39:38] zero
    output logic [39:0] m_tdata
);

    // Buffer address width and the nibble index width, which spans twice
    // the buffer so that it counts nibbles rather than bytes.
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int IW = $clog2(2 * BUFFER_BYTES);

    logic                        accept;
    logic                        s1_valid, s1_ready;
    jns_pkg::stage_t             s1_stage;
    jns_pkg::ctrl_status_t       status;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [7:0]                  rd_data;
    logic [jns_pkg::RDATA_W-1:0] read_data;
    logic                        tck_pulse, tms_out, tdi_out, test_out, rst_out, busy_res;

    // A new transaction enters whenever the decode stage is empty or is
    // handing its contents on to the output register in the same cycle.
    assign s_tready = !s1_valid || s1_ready;
    assign accept   = s_tvalid && s_tready;

    jns_cmd_buf #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (accept && (s_tuser == jns_pkg::CMD_WRITE_BUF)),
        .wr_addr (s_tdata[9:0]),
        .wr_data (s_tdata[17:10]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The control stage owns everything that does not depend on the command
    // nibble itself, so a run's bookkeeping is settled at acceptance.
    jns_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW),
        .IW           (IW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .cmd           (s_tuser),
        .start_bit     (s_tdata[18]),
        .use_test_rst  (s_tdata[19]),
        .command_count (s_tdata[43:20]),
        .tdo_pin       (s_tdata[44]),
        .s1_ready      (s1_ready),
        .s1_valid      (s1_valid),
        .s1_stage      (s1_stage),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .status        (status)
    );

    // The execute stage drives the pins and the TDO shift register from the
    // nibble, and holds the result until the downstream side takes it.
    jns_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s1_valid  (s1_valid),
        .s1_stage  (s1_stage),
        .rd_data   (rd_data),
        .s1_ready  (s1_ready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .read_data (read_data),
        .tck_pulse (tck_pulse),
        .tms_out   (tms_out),
        .tdi_out   (tdi_out),
        .test_out  (test_out),
        .rst_out   (rst_out),
        .busy_res  (busy_res)
    );

    assign m_tdata = {2'b00, busy_res, rst_out, test_out, tdi_out, tms_out,
                      tck_pulse, read_data};

    // A running sequencer always has commands still to execute.
    a_run_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        status.running |-> !status.left_zero)
        else $error("run in progress with no commands left");

    // A stalled decode stage keeps its contents for the next cycle.
    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_stage)))
        else $error("decode stage lost or changed while stalled");

    // A TCK pulse only comes from a tick, which never carries read data.
    a_tick_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && tck_pulse) |-> (read_data == '0))
        else $error("TCK pulse reported together with read data");

    // A tick only reaches the decode stage while a run is in progress.
    a_tick_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == jns_pkg::CMD_TICK) && !status.running)
        |=> !s1_stage.exec_tick)
        else $error("tick executed while idle");

endmodule
